@@ hw/rtl/assert_macros.svh @@
// Assertion helper macros shared by the RTL.
// Define ASSERT_OFF to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ hw/rtl/wsm_pkg.sv @@
`default_nettype none

package wsm_pkg;

   // Default frame limits.
   localparam int MAX_COLS_DEF   = 1024;
   localparam int MAX_ROWS_DEF   = 1024;

   // Field and datapath widths.
   localparam int PIXEL_BITS     = 16;
   localparam int SIZE_BITS      = 13;
   localparam int CFG_SIZE_BITS  = 11;
   localparam int WEIGHT_BITS    = 8;
   localparam int PROD_BITS      = PIXEL_BITS + WEIGHT_BITS;
   localparam int SUM_BITS       = 28;
   localparam int WSUM_BITS      = 12;
   localparam int CHECK_BITS     = 40;
   localparam int POS_BITS       = 10;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 11;
   localparam int DIV_STEPS      = PIXEL_BITS;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_IMAGE_ROWS    = 3'd0,
      CSR_IMAGE_COLS    = 3'd1,
      CSR_CENTRE_WEIGHT = 3'd2,
      CSR_SIDE_WEIGHT   = 3'd3,
      CSR_CORNER_WEIGHT = 3'd4
   } csr_index_type;

   typedef enum logic {
      FUNC_PIXEL = 1'b0,
      FUNC_DRAIN = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      POS_LEFT,
      POS_MID,
      POS_RIGHT
   } pos_type;

   typedef enum logic [1:0] {
      JOB_FIRST,
      JOB_ROW_END,
      JOB_DRAIN
   } job_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EVAL,
      ST_RD_LEFT,
      ST_RD_MID,
      ST_RD_RIGHT,
      ST_ACC,
      ST_DIV_GO,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      func_type                func;
      logic [PIXEL_BITS-1:0]   pixel;
   } req_data_type;

   typedef struct packed {
      logic [POS_BITS-1:0]     out_row;
      logic [POS_BITS-1:0]     out_col;
      logic [PIXEL_BITS-1:0]   filtered;
      logic [CHECK_BITS-1:0]   checksum;
      logic                    frame_last;
   } rsp_data_type;

   typedef struct packed {
      logic    capture;
      logic    write_pixel;
      logic    update;
      logic    acc_clear;
      logic    acc_en;
      pos_type rd_pos;
      pos_type acc_pos;
      job_type job;
      logic    div_start;
      logic    out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_drain;
      logic loaded;
      logic first_ok;
      logic rowend_ok;
      logic div_busy;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

@@ hw/rtl/weighted_3x3_smoothing.sv @@
// An item that yields no result is only captured and evaluated.
// Each result takes three buffer reads, accumulate, divider start, the divide and load;
// an item yields zero, one or two results, and no new item is taken until it is done.
// Reset is synchronous and active high; it restores the default settings and
// starts a new frame. Line buffers need no clearing and the block is ready at once.
`default_nettype none
`include "assert_macros.svh"

module weighted_3x3_smoothing #(
   parameter int MAX_COLS = wsm_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS = wsm_pkg::MAX_ROWS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire wsm_pkg::req_data_type                req_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output wsm_pkg::rsp_data_type                     rsp_data,
   input  wire logic                                 csr_write,
   input  wire logic [wsm_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [wsm_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   wsm_pkg::ctrl_cmd_type  cmd;
   wsm_pkg::dp_status_type status;

   wsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   wsm_dp #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

   // The sequencer takes no new item while one is in progress.
   `ASSERT_NEXT(a_busy_after_transfer, clock, reset, req_valid && !req_stall, req_stall)
   // A result is loaded only into a free result register.
   `ASSERT_IMPLIES(a_load_when_free, clock, reset, cmd.out_load, status.out_free)
   // The divider is never restarted mid-division.
   `ASSERT_IMPLIES(a_div_idle_on_start, clock, reset, cmd.div_start, !status.div_busy)

endmodule

`default_nettype wire

@@ hw/rtl/wsm_div.sv @@
`default_nettype none

// Restoring divider, one quotient bit per cycle. The quotient is known to fit
// in DIV_STEPS bits because it is a weighted average of pixels.
module wsm_div (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [wsm_pkg::SUM_BITS-1:0]      dividend,
   input  wire logic [wsm_pkg::WSUM_BITS-1:0]     divisor,
   output logic                                   busy,
   output logic [wsm_pkg::PIXEL_BITS-1:0]         quotient
);

   localparam int CNT_W = $clog2(wsm_pkg::DIV_STEPS);

   logic                              busy_ff;
   logic [CNT_W-1:0]                  cnt_ff;
   logic [wsm_pkg::SUM_BITS-1:0]      rem_ff;
   logic [wsm_pkg::SUM_BITS-1:0]      dsh_ff;
   logic [wsm_pkg::PIXEL_BITS-1:0]    quot_ff;
   logic                              fits;

   // Trial subtraction of the shifted divisor.
   assign fits = (rem_ff >= dsh_ff);

   // Step counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(wsm_pkg::DIV_STEPS - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // Remainder, shifted divisor and quotient.
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= dividend;
         dsh_ff  <= wsm_pkg::SUM_BITS'(divisor) << (wsm_pkg::DIV_STEPS - 1);
         quot_ff <= '0;
      end else if (busy_ff) begin
         if (fits) begin
            rem_ff <= rem_ff - dsh_ff;
         end
         dsh_ff  <= dsh_ff >> 1;
         quot_ff <= {quot_ff[wsm_pkg::PIXEL_BITS-2:0], fits};
      end
   end

   assign busy     = busy_ff;
   assign quotient = quot_ff;

endmodule

`default_nettype wire

@@ hw/rtl/wsm_ctrl.sv @@
`default_nettype none

// Sequencer: takes one item, runs up to two filter jobs for it, then commits
// the position update; a drain item before the frame is loaded, or a pixel item after it, is dropped.
module wsm_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire wsm_pkg::dp_status_type   status,
   output wsm_pkg::ctrl_cmd_type         cmd
);

   wsm_pkg::state_type state_ff, state_in;
   wsm_pkg::job_type   job_ff, job_in;

   // State and job registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wsm_pkg::ST_IDLE;
         job_ff   <= wsm_pkg::JOB_FIRST;
      end else begin
         state_ff <= state_in;
         job_ff   <= job_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      unique case (state_ff)
         wsm_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = wsm_pkg::ST_EVAL;
            end
         end
         wsm_pkg::ST_EVAL: begin
            state_in = wsm_pkg::ST_IDLE;
            if (status.is_drain) begin
               if (status.loaded) begin
                  job_in   = wsm_pkg::JOB_DRAIN;
                  state_in = wsm_pkg::ST_RD_LEFT;
               end
            end else if (!status.loaded) begin
               if (status.first_ok) begin
                  job_in   = wsm_pkg::JOB_FIRST;
                  state_in = wsm_pkg::ST_RD_LEFT;
               end else if (status.rowend_ok) begin
                  job_in   = wsm_pkg::JOB_ROW_END;
                  state_in = wsm_pkg::ST_RD_LEFT;
               end
            end
         end
         wsm_pkg::ST_RD_LEFT:  state_in = wsm_pkg::ST_RD_MID;
         wsm_pkg::ST_RD_MID:   state_in = wsm_pkg::ST_RD_RIGHT;
         wsm_pkg::ST_RD_RIGHT: state_in = wsm_pkg::ST_ACC;
         wsm_pkg::ST_ACC:      state_in = wsm_pkg::ST_DIV_GO;
         wsm_pkg::ST_DIV_GO:   state_in = wsm_pkg::ST_DIV;
         wsm_pkg::ST_DIV: begin
            if (!status.div_busy) begin
               state_in = wsm_pkg::ST_OUT;
            end
         end
         wsm_pkg::ST_OUT: begin
            if (status.out_free) begin
               if (job_ff == wsm_pkg::JOB_FIRST && status.rowend_ok) begin
                  job_in   = wsm_pkg::JOB_ROW_END;
                  state_in = wsm_pkg::ST_RD_LEFT;
               end else begin
                  state_in = wsm_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = wsm_pkg::ST_IDLE;
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd           = '0;
      cmd.rd_pos    = wsm_pkg::POS_LEFT;
      cmd.acc_pos   = wsm_pkg::POS_LEFT;
      cmd.job       = job_ff;
      req_stall     = (state_ff != wsm_pkg::ST_IDLE);
      unique case (state_ff)
         wsm_pkg::ST_IDLE: begin
            cmd.capture = req_valid;
         end
         wsm_pkg::ST_EVAL: begin
            if (!status.is_drain && !status.loaded) begin
               cmd.write_pixel = 1'b1;
               cmd.update      = !status.first_ok && !status.rowend_ok;
            end
         end
         wsm_pkg::ST_RD_LEFT: begin
            cmd.rd_pos    = wsm_pkg::POS_LEFT;
            cmd.acc_clear = 1'b1;
         end
         wsm_pkg::ST_RD_MID: begin
            cmd.rd_pos  = wsm_pkg::POS_MID;
            cmd.acc_en  = 1'b1;
            cmd.acc_pos = wsm_pkg::POS_LEFT;
         end
         wsm_pkg::ST_RD_RIGHT: begin
            cmd.rd_pos  = wsm_pkg::POS_RIGHT;
            cmd.acc_en  = 1'b1;
            cmd.acc_pos = wsm_pkg::POS_MID;
         end
         wsm_pkg::ST_ACC: begin
            cmd.acc_en  = 1'b1;
            cmd.acc_pos = wsm_pkg::POS_RIGHT;
         end
         wsm_pkg::ST_DIV_GO: begin
            cmd.div_start = 1'b1;
         end
         wsm_pkg::ST_DIV: begin
            cmd.div_start = 1'b0;
         end
         wsm_pkg::ST_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.update   = !(job_ff == wsm_pkg::JOB_FIRST && status.rowend_ok);
            end
         end
         default: cmd = '0;
      endcase
   end

endmodule

`default_nettype wire

@@ hw/rtl/wsm_dp.sv @@
`default_nettype none

// Datapath: settings, position counters, three rotating line buffers,
// weighted accumulator, divider and the result register.
module wsm_dp #(
   parameter int MAX_COLS = wsm_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS = wsm_pkg::MAX_ROWS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire wsm_pkg::req_data_type                req_data,
   input  wire logic                                 csr_write,
   input  wire logic [wsm_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [wsm_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   input  wire logic                                 rsp_stall,
   output logic                                      rsp_valid,
   output wsm_pkg::rsp_data_type                     rsp_data,
   input  wire wsm_pkg::ctrl_cmd_type                cmd,
   output wsm_pkg::dp_status_type                    status
);

   localparam int COL_W = $clog2(MAX_COLS);
   localparam int ROW_W = $clog2(MAX_ROWS);
   localparam int SZ    = wsm_pkg::SIZE_BITS;
   localparam int PW    = wsm_pkg::PIXEL_BITS;
   localparam int WW    = wsm_pkg::WEIGHT_BITS;

   // Settings.
   logic [wsm_pkg::CFG_SIZE_BITS-1:0] rows_cfg_ff, cols_cfg_ff;
   logic [WW-1:0]                     centre_w_ff, side_w_ff, corner_w_ff;

   // Position and frame state.
   logic [ROW_W-1:0]                  in_row_ff;
   logic [COL_W-1:0]                  in_col_ff, drain_col_ff;
   logic                              loaded_ff;
   logic [1:0]                        rot_ff;
   logic [wsm_pkg::CHECK_BITS-1:0]    running_ff;

   // Item, buffers and accumulators.
   wsm_pkg::req_data_type             item_ff;
   logic [PW-1:0]                     line_a_mem [MAX_COLS];
   logic [PW-1:0]                     line_b_mem [MAX_COLS];
   logic [PW-1:0]                     line_c_mem [MAX_COLS];
   logic [PW-1:0]                     a_rd_ff, b_rd_ff, c_rd_ff;
   logic [wsm_pkg::SUM_BITS-1:0]      sum_ff, sum_in;
   logic [wsm_pkg::WSUM_BITS-1:0]     wt_ff, wt_in;
   logic                              rsp_valid_ff;
   wsm_pkg::rsp_data_type             rsp_data_ff;

   // Derived values.
   logic [SZ-1:0]                     rows_eff, cols_eff;
   logic [COL_W-1:0]                  col_eff;
   logic                              row_end, frame_end, drain_last;
   logic [SZ-1:0]                     job_row, job_col, col_m1, col_p1;
   logic                              has_up, has_down, has_left, has_right;
   logic [COL_W-1:0]                  rd_addr;
   logic [PW-1:0]                     older_px, prev_px, curr_px;
   logic                              col_en, eu, em, ed;
   logic [WW-1:0]                     wu, wm, wu_e, wm_e, wd_e;
   logic [PW-1:0]                     pu_e, pm_e, pd_e;
   logic [wsm_pkg::PROD_BITS-1:0]     prod_u, prod_m, prod_d;
   logic                              div_busy;
   logic [PW-1:0]                     quot, filtered;
   logic [wsm_pkg::CHECK_BITS-1:0]    run_sum;
   logic                              out_free;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_cfg_ff <= wsm_pkg::CFG_SIZE_BITS'(1024);
         cols_cfg_ff <= wsm_pkg::CFG_SIZE_BITS'(1024);
         centre_w_ff <= WW'(4);
         side_w_ff   <= WW'(2);
         corner_w_ff <= WW'(1);
      end else if (csr_write) begin
         unique case (wsm_pkg::csr_index_type'(csr_index))
            wsm_pkg::CSR_IMAGE_ROWS:    rows_cfg_ff <= csr_wdata;
            wsm_pkg::CSR_IMAGE_COLS:    cols_cfg_ff <= csr_wdata;
            wsm_pkg::CSR_CENTRE_WEIGHT: centre_w_ff <= csr_wdata[WW-1:0];
            wsm_pkg::CSR_SIDE_WEIGHT:   side_w_ff   <= csr_wdata[WW-1:0];
            wsm_pkg::CSR_CORNER_WEIGHT: corner_w_ff <= csr_wdata[WW-1:0];
            default: ;
         endcase
      end
   end

   // Frame size clamped to the supported range.
   always_comb begin
      rows_eff = SZ'(rows_cfg_ff);
      if (rows_eff < SZ'(2)) begin
         rows_eff = SZ'(2);
      end else if (rows_eff > SZ'(MAX_ROWS)) begin
         rows_eff = SZ'(MAX_ROWS);
      end
      cols_eff = SZ'(cols_cfg_ff);
      if (cols_eff < SZ'(2)) begin
         cols_eff = SZ'(2);
      end else if (cols_eff > SZ'(MAX_COLS)) begin
         cols_eff = SZ'(MAX_COLS);
      end
   end

   // Position tests for the current item.
   assign col_eff    = (SZ'(in_col_ff) >= SZ'(MAX_COLS)) ? COL_W'(MAX_COLS - 1) : in_col_ff;
   assign row_end    = (SZ'(col_eff) + SZ'(1)) >= cols_eff;
   assign frame_end  = (SZ'(in_row_ff) + SZ'(1)) >= rows_eff;
   assign drain_last = (SZ'(drain_col_ff) + SZ'(1)) >= cols_eff;

   // Item register.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_data;
      end
   end

   // Position counters, buffer rotation and frame state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_row_ff    <= '0;
         in_col_ff    <= '0;
         drain_col_ff <= '0;
         loaded_ff    <= 1'b0;
         rot_ff       <= 2'd0;
      end else if (cmd.update) begin
         if (item_ff.func == wsm_pkg::FUNC_DRAIN) begin
            if (drain_last) begin
               loaded_ff    <= 1'b0;
               drain_col_ff <= '0;
               in_row_ff    <= '0;
               in_col_ff    <= '0;
            end else begin
               drain_col_ff <= drain_col_ff + COL_W'(1);
            end
         end else if (row_end) begin
            rot_ff    <= (rot_ff == 2'd2) ? 2'd0 : rot_ff + 2'd1;
            in_col_ff <= '0;
            if (frame_end) begin
               in_row_ff    <= '0;
               drain_col_ff <= '0;
               loaded_ff    <= 1'b1;
            end else begin
               in_row_ff <= in_row_ff + ROW_W'(1);
            end
         end else begin
            in_col_ff <= col_eff + COL_W'(1);
         end
      end
   end

   // Job geometry: which output pixel and which neighbours exist.
   always_comb begin
      job_row  = SZ'(in_row_ff) - SZ'(1);
      job_col  = SZ'(col_eff) - SZ'(1);
      has_up   = (in_row_ff > ROW_W'(1));
      has_down = 1'b1;
      unique case (cmd.job)
         wsm_pkg::JOB_FIRST: begin
            job_col = SZ'(col_eff) - SZ'(1);
         end
         wsm_pkg::JOB_ROW_END: begin
            job_col = SZ'(col_eff);
         end
         wsm_pkg::JOB_DRAIN: begin
            job_row  = rows_eff - SZ'(1);
            job_col  = SZ'(drain_col_ff);
            has_up   = 1'b1;
            has_down = 1'b0;
         end
         default: ;
      endcase
   end

   assign col_m1    = job_col - SZ'(1);
   assign col_p1    = job_col + SZ'(1);
   assign has_left  = (job_col != '0);
   assign has_right = (col_p1 < cols_eff);

   // Read address for the column being fetched.
   always_comb begin
      unique case (cmd.rd_pos)
         wsm_pkg::POS_LEFT:  rd_addr = col_m1[COL_W-1:0];
         wsm_pkg::POS_MID:   rd_addr = job_col[COL_W-1:0];
         wsm_pkg::POS_RIGHT: rd_addr = col_p1[COL_W-1:0];
         default:            rd_addr = job_col[COL_W-1:0];
      endcase
   end

   // Line buffer A.
   always_ff @(posedge clock) begin
      if (cmd.write_pixel && rot_ff == 2'd0) begin
         line_a_mem[col_eff] <= item_ff.pixel;
      end
      a_rd_ff <= line_a_mem[rd_addr];
   end

   // Line buffer B.
   always_ff @(posedge clock) begin
      if (cmd.write_pixel && rot_ff == 2'd1) begin
         line_b_mem[col_eff] <= item_ff.pixel;
      end
      b_rd_ff <= line_b_mem[rd_addr];
   end

   // Line buffer C.
   always_ff @(posedge clock) begin
      if (cmd.write_pixel && rot_ff == 2'd2) begin
         line_c_mem[col_eff] <= item_ff.pixel;
      end
      c_rd_ff <= line_c_mem[rd_addr];
   end

   // Map buffers to rows: the rotation names the buffer taking new pixels.
   always_comb begin
      case (rot_ff)
         2'd1: begin
            curr_px  = b_rd_ff;
            prev_px  = a_rd_ff;
            older_px = c_rd_ff;
         end
         2'd2: begin
            curr_px  = c_rd_ff;
            prev_px  = b_rd_ff;
            older_px = a_rd_ff;
         end
         default: begin
            curr_px  = a_rd_ff;
            prev_px  = c_rd_ff;
            older_px = b_rd_ff;
         end
      endcase
   end

   // Weights of the column being accumulated.
   always_comb begin
      col_en = 1'b1;
      wu     = side_w_ff;
      wm     = centre_w_ff;
      case (cmd.acc_pos)
         wsm_pkg::POS_LEFT: begin
            col_en = has_left;
            wu     = corner_w_ff;
            wm     = side_w_ff;
         end
         wsm_pkg::POS_RIGHT: begin
            col_en = has_right;
            wu     = corner_w_ff;
            wm     = side_w_ff;
         end
         default: ;
      endcase
   end

   // Missing neighbours contribute neither pixel nor weight.
   assign eu   = col_en && has_up;
   assign em   = col_en;
   assign ed   = col_en && has_down;
   assign wu_e = eu ? wu : '0;
   assign wm_e = em ? wm : '0;
   assign wd_e = ed ? wu : '0;
   assign pu_e = eu ? older_px : '0;
   assign pm_e = em ? prev_px : '0;
   assign pd_e = ed ? curr_px : '0;

   assign prod_u = wsm_pkg::PROD_BITS'(pu_e) * wsm_pkg::PROD_BITS'(wu_e);
   assign prod_m = wsm_pkg::PROD_BITS'(pm_e) * wsm_pkg::PROD_BITS'(wm_e);
   assign prod_d = wsm_pkg::PROD_BITS'(pd_e) * wsm_pkg::PROD_BITS'(wd_e);

   assign sum_in = sum_ff + wsm_pkg::SUM_BITS'(prod_u) + wsm_pkg::SUM_BITS'(prod_m)
                 + wsm_pkg::SUM_BITS'(prod_d);
   assign wt_in  = wt_ff + wsm_pkg::WSUM_BITS'(wu_e) + wsm_pkg::WSUM_BITS'(wm_e)
                 + wsm_pkg::WSUM_BITS'(wd_e);

   // Accumulators.
   always_ff @(posedge clock) begin
      if (cmd.acc_clear) begin
         sum_ff <= '0;
         wt_ff  <= '0;
      end else if (cmd.acc_en) begin
         sum_ff <= sum_in;
         wt_ff  <= wt_in;
      end
   end

   wsm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (sum_ff),
      .divisor  (wt_ff),
      .busy     (div_busy),
      .quotient (quot)
   );

   // A zero weight total gives zero.
   assign filtered = (wt_ff == '0) ? '0 : quot;
   assign run_sum  = running_ff + wsm_pkg::CHECK_BITS'(filtered);

   // Running checksum; cleared when the frame's final result is loaded into the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= '0;
      end else begin
         if (cmd.out_load) begin
            running_ff <= run_sum;
         end
         if (cmd.update && item_ff.func == wsm_pkg::FUNC_DRAIN && drain_last) begin
            running_ff <= '0;
         end
      end
   end

   // Result register.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff.out_row    <= job_row[wsm_pkg::POS_BITS-1:0];
         rsp_data_ff.out_col    <= job_col[wsm_pkg::POS_BITS-1:0];
         rsp_data_ff.filtered   <= filtered;
         rsp_data_ff.checksum   <= run_sum;
         rsp_data_ff.frame_last <= (cmd.job == wsm_pkg::JOB_DRAIN) && drain_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Status to the sequencer.
   assign status.is_drain  = (item_ff.func == wsm_pkg::FUNC_DRAIN);
   assign status.loaded    = loaded_ff;
   assign status.first_ok  = (in_row_ff != '0) && (col_eff != '0);
   assign status.rowend_ok = row_end && (in_row_ff != '0);
   assign status.div_busy  = div_busy;
   assign status.out_free  = out_free;

endmodule

`default_nettype wire
